@@ hdl/tpfl_pkg.sv @@
// Package for the two-pool page free-list allocator: shared codes, register
// reset values and the control structs passed between the modules.
// No dependencies.
`default_nettype none

package tpfl_pkg;

    // Item kinds.
    typedef enum logic [2:0] {
        KIND_ALLOC_SMALL = 3'd0,
        KIND_ALLOC_SUPER = 3'd1,
        KIND_FREE_SMALL  = 3'd2,
        KIND_FREE_SUPER  = 3'd3,
        KIND_INIT        = 3'd4
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_BAD   = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_DONE
    } ctrl_state_t;

    // Which pool supplies the page address of a result.
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_SMALL,
        SRC_SUPER
    } page_src_t;

    // Configuration register file.
    localparam int PADDR_W = 4;
    localparam logic [PADDR_W-1:0] ADDR_FREE_LOW    = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_SUPER_START = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_PHYS_TOP    = 4'h8;

    localparam logic [31:0] FREE_LOW_RESET    = 32'h8010_0000;
    localparam logic [31:0] SUPER_START_RESET = 32'h8200_0000;
    localparam logic [31:0] PHYS_TOP_RESET    = 32'h8800_0000;

    typedef struct packed {
        logic [31:0] free_low;
        logic [31:0] super_start;
        logic [31:0] phys_top;
    } cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic exec;      // item accepted this cycle, run its stack operation
        logic init_fin;  // follows an accepted init item, set the stack tops
        logic load_out;  // move the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_busy;  // output register full and not taken this cycle
    } ctrl_stat_t;

    // Datapath to one pool.
    typedef struct packed {
        logic pop;
        logic push;
        logic init_start;
        logic init_fin;
    } pool_cmd_t;

    // Pool to datapath.
    typedef struct packed {
        logic empty;
        logic bad;
        logic full;
        logic ovf;
    } pool_stat_t;

endpackage

`default_nettype wire

@@ hdl/tpfl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tpfl_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/tpfl_pool.sv @@
// One free-page stack: stack memory, top pointer and the init watermark.
// Depends on tpfl_pkg and tpfl_ram.
`default_nettype none

module tpfl_pool
    import tpfl_pkg::*;
#(
    parameter int SHIFT = 12,
    parameter int DEPTH = 8192,
    localparam int TW = $clog2(DEPTH + 1)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pool_cmd_t   cmd,
    input  wire logic [31:0] address,
    input  wire logic [31:0] lo,
    input  wire logic [31:0] hi,
    output pool_stat_t       stat,
    output logic [TW-1:0]    top,
    output logic [31:0]      page_address
);

    localparam int AW  = $clog2(DEPTH);
    localparam int PW  = 32 - SHIFT;
    localparam int LPW = PW + 1;
    localparam int CW  = (LPW > TW) ? LPW : TW;
    localparam logic [31:0] ALIGN_MASK = 32'((64'd1 << SHIFT) - 64'd1);

    // Init does not sweep the memory. Entries below wm_reg still hold the
    // ascending run base_reg, base_reg+1, ...; entries from wm_reg up to the
    // top were pushed since the last init and live in the RAM.
    logic [TW-1:0]  top_reg, top_next;
    logic [TW-1:0]  wm_reg, wm_next;
    logic [LPW-1:0] base_reg, base_next;
    logic [PW-1:0]  hipn_reg, hipn_next;
    logic           impl_reg, impl_next;
    logic [PW-1:0]  implv_reg, implv_next;

    logic [TW-1:0]  pop_idx;
    logic [32:0]    lo_round;
    logic [LPW-1:0] span;
    logic           do_push;
    logic           do_pop;
    logic [PW-1:0]  ram_rdata;

    assign pop_idx  = top_reg - TW'(1);
    assign lo_round = {1'b0, lo} + 33'((33'd1 << SHIFT) - 33'd1);
    assign span     = ({1'b0, hipn_reg} > base_reg) ? ({1'b0, hipn_reg} - base_reg) : '0;

    always_comb
    begin
        stat.empty = (top_reg == '0);
        stat.full  = (top_reg >= TW'(DEPTH));
        stat.bad   = ((address & ALIGN_MASK) != 32'd0) || (address < lo) || (address >= hi);
        stat.ovf   = (CW'(span) > CW'(DEPTH));
    end

    assign do_push = cmd.push && !stat.bad && !stat.full;
    assign do_pop  = cmd.pop && !stat.empty;

    always_comb
    begin
        top_next   = top_reg;
        wm_next    = wm_reg;
        base_next  = base_reg;
        hipn_next  = hipn_reg;
        impl_next  = impl_reg;
        implv_next = implv_reg;
        if (cmd.init_start)
        begin
            base_next = lo_round[32:SHIFT];
            hipn_next = hi[31:SHIFT];
        end
        priority if (cmd.init_fin)
        begin
            top_next = stat.ovf ? TW'(DEPTH) : TW'(span);
            wm_next  = top_next;
        end
        else if (do_push)
        begin
            top_next = top_reg + TW'(1);
            if (top_reg < wm_reg)
            begin
                wm_next = top_reg;
            end
        end
        else if (do_pop)
        begin
            top_next   = pop_idx;
            impl_next  = (pop_idx < wm_reg);
            implv_next = PW'(base_reg + LPW'(pop_idx));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            wm_reg  <= '0;
        end
        else
        begin
            top_reg <= top_next;
            wm_reg  <= wm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        hipn_reg  <= hipn_next;
        impl_reg  <= impl_next;
        implv_reg <= implv_next;
    end

    tpfl_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (do_push),
        .waddr (top_reg[AW-1:0]),
        .wdata (address[31:SHIFT]),
        .re    (do_pop),
        .raddr (pop_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign top          = top_reg;
    assign page_address = {(impl_reg ? implv_reg : ram_rdata), {SHIFT{1'b0}}};

    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(DEPTH))
        else $error("stack top beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !cmd.init_fin |=> top_reg == $past(top_reg) + TW'(1))
        else $error("push did not advance the top");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        do_pop && !cmd.init_fin && !do_push |=> top_reg == $past(top_reg) - TW'(1))
        else $error("pop did not lower the top");

endmodule

`default_nettype wire

@@ hdl/tpfl_datapath.sv @@
// Datapath: both page pools, result status and the output register.
// Depends on tpfl_pkg and tpfl_pool.
`default_nettype none

module tpfl_datapath
    import tpfl_pkg::*;
#(
    parameter int PAGE_SHIFT  = 12,
    parameter int SUPER_SHIFT = 21,
    parameter int SMALL_DEPTH = 8192,
    parameter int SUPER_DEPTH = 64,
    localparam int STW = $clog2(SMALL_DEPTH + 1),
    localparam int PTW = $clog2(SUPER_DEPTH + 1)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ctrl_cmd_t   cmd,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] address,
    input  wire cfg_t        cfg,
    input  wire logic        rsp_stall,
    output ctrl_stat_t       stat,
    output logic             rsp_valid,
    output logic [31:0]      page_address,
    output logic [1:0]       status,
    output logic [STW-1:0]   small_free_count,
    output logic [PTW-1:0]   super_free_count
);

    pool_cmd_t      small_cmd, super_cmd;
    pool_stat_t     small_stat, super_stat;
    logic [STW-1:0] small_top;
    logic [PTW-1:0] super_top;
    logic [31:0]    small_page, super_page;

    status_t   status_reg, status_next;
    page_src_t src_reg, src_next;

    logic           out_valid_reg, out_valid_next;
    logic [31:0]    out_page_reg;
    logic [1:0]     out_status_reg;
    logic [STW-1:0] out_small_reg;
    logic [PTW-1:0] out_super_reg;

    always_comb
    begin
        small_cmd.pop        = cmd.exec && (kind == KIND_ALLOC_SMALL);
        small_cmd.push       = cmd.exec && (kind == KIND_FREE_SMALL);
        small_cmd.init_start = cmd.exec && (kind == KIND_INIT);
        small_cmd.init_fin   = cmd.init_fin;
        super_cmd.pop        = cmd.exec && (kind == KIND_ALLOC_SUPER);
        super_cmd.push       = cmd.exec && (kind == KIND_FREE_SUPER);
        super_cmd.init_start = cmd.exec && (kind == KIND_INIT);
        super_cmd.init_fin   = cmd.init_fin;
    end

    tpfl_pool #(
        .SHIFT (PAGE_SHIFT),
        .DEPTH (SMALL_DEPTH)
    ) u_small (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (small_cmd),
        .address      (address),
        .lo           (cfg.free_low),
        .hi           (cfg.super_start),
        .stat         (small_stat),
        .top          (small_top),
        .page_address (small_page)
    );

    tpfl_pool #(
        .SHIFT (SUPER_SHIFT),
        .DEPTH (SUPER_DEPTH)
    ) u_super (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (super_cmd),
        .address      (address),
        .lo           (cfg.super_start),
        .hi           (cfg.phys_top),
        .stat         (super_stat),
        .top          (super_top),
        .page_address (super_page)
    );

    always_comb
    begin
        status_next = status_reg;
        src_next    = src_reg;
        if (cmd.exec)
        begin
            src_next = SRC_NONE;
            unique case (kind)
                KIND_ALLOC_SMALL:
                begin
                    status_next = small_stat.empty ? STATUS_EMPTY : STATUS_OK;
                    src_next    = small_stat.empty ? SRC_NONE : SRC_SMALL;
                end
                KIND_ALLOC_SUPER:
                begin
                    status_next = super_stat.empty ? STATUS_EMPTY : STATUS_OK;
                    src_next    = super_stat.empty ? SRC_NONE : SRC_SUPER;
                end
                KIND_FREE_SMALL:
                begin
                    status_next = small_stat.bad  ? STATUS_BAD  :
                                  small_stat.full ? STATUS_FULL : STATUS_OK;
                end
                KIND_FREE_SUPER:
                begin
                    status_next = super_stat.bad  ? STATUS_BAD  :
                                  super_stat.full ? STATUS_FULL : STATUS_OK;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
        else if (cmd.init_fin)
        begin
            status_next = (small_stat.ovf || super_stat.ovf) ? STATUS_FULL : STATUS_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            src_reg       <= SRC_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            src_reg       <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            unique case (src_reg)
                SRC_SMALL: out_page_reg <= small_page;
                SRC_SUPER: out_page_reg <= super_page;
                default:   out_page_reg <= 32'd0;
            endcase
            out_status_reg <= status_reg;
            out_small_reg  <= small_top;
            out_super_reg  <= super_top;
        end
    end

    assign stat.out_busy    = out_valid_reg && rsp_stall;
    assign rsp_valid        = out_valid_reg;
    assign page_address     = out_page_reg;
    assign status           = out_status_reg;
    assign small_free_count = out_small_reg;
    assign super_free_count = out_super_reg;

endmodule

`default_nettype wire

@@ hdl/tpfl_ctrl.sv @@
// Controller state machine: input handshake and sequencing of the datapath.
// Depends on tpfl_pkg.
`default_nettype none

module tpfl_ctrl
    import tpfl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire logic [2:0] kind,
    input  wire ctrl_stat_t stat,
    output logic            req_stall,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (kind == KIND_INIT) ? ST_INIT : ST_DONE;
                end
            end
            ST_INIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall    = 1'b1;
        cmd.exec     = 1'b0;
        cmd.init_fin = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.exec  = req_valid;
            end
            ST_INIT:
            begin
                cmd.init_fin = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = !stat.out_busy;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_load_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> !cmd.load_out)
        else $error("result loaded twice");

    a_init_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_fin |-> $past(cmd.exec) && $past(kind) == KIND_INIT)
        else $error("init finish without an init item");

endmodule

`default_nettype wire

@@ hdl/two_pool_page_free_list_allocator.sv @@
// Top level of the two-pool page free-list allocator: configuration registers
// and the controller and datapath. Depends on tpfl_pkg, tpfl_ctrl, tpfl_datapath.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  kind, address
// rsp       out        rsp_valid / rsp_stall  page_address, status,
//                                             small_free_count, super_free_count
// cfg       in         APB psel/penable       paddr, pwdata, prdata
//
// Alloc and free update the stack top and access the stack RAM when the item
// is accepted; ST_DONE then moves the registered RAM read into the output
// register. Init first rounds the region bounds to page numbers, then sets
// both tops in ST_INIT. Init writes no RAM entry; the pages it pushes are
// implied by the stored base page number until a free overwrites them.
// No clearing pass is needed after reset. A stalled output register holds
// the finished result and keeps the next item waiting.
`default_nettype none

module two_pool_page_free_list_allocator
    import tpfl_pkg::*;
#(
    parameter int PAGE_SHIFT  = 12,
    parameter int SUPER_SHIFT = 21,
    parameter int SMALL_DEPTH = 8192,
    parameter int SUPER_DEPTH = 64,
    localparam int STW = $clog2(SMALL_DEPTH + 1),
    localparam int PTW = $clog2(SUPER_DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [2:0]         kind,
    input  wire logic [31:0]        address,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic      [31:0]        page_address,
    output logic      [1:0]         status,
    output logic      [STW-1:0]     small_free_count,
    output logic      [PTW-1:0]     super_free_count
);

    cfg_t       cfg_reg;
    logic       cfg_write;
    ctrl_cmd_t  cmd;
    ctrl_stat_t dstat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.free_low    <= FREE_LOW_RESET;
            cfg_reg.super_start <= SUPER_START_RESET;
            cfg_reg.phys_top    <= PHYS_TOP_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr == ADDR_FREE_LOW)
            begin
                cfg_reg.free_low <= pwdata;
            end
            if (paddr == ADDR_SUPER_START)
            begin
                cfg_reg.super_start <= pwdata;
            end
            if (paddr == ADDR_PHYS_TOP)
            begin
                cfg_reg.phys_top <= pwdata;
            end
        end
    end

    always_comb
    begin
        priority if (paddr == ADDR_FREE_LOW)
        begin
            prdata = cfg_reg.free_low;
        end
        else if (paddr == ADDR_SUPER_START)
        begin
            prdata = cfg_reg.super_start;
        end
        else if (paddr == ADDR_PHYS_TOP)
        begin
            prdata = cfg_reg.phys_top;
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    tpfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .kind      (kind),
        .stat      (dstat),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    tpfl_datapath #(
        .PAGE_SHIFT  (PAGE_SHIFT),
        .SUPER_SHIFT (SUPER_SHIFT),
        .SMALL_DEPTH (SMALL_DEPTH),
        .SUPER_DEPTH (SUPER_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .kind             (kind),
        .address          (address),
        .cfg              (cfg_reg),
        .rsp_stall        (rsp_stall),
        .stat             (dstat),
        .rsp_valid        (rsp_valid),
        .page_address     (page_address),
        .status           (status),
        .small_free_count (small_free_count),
        .super_free_count (super_free_count)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_two_pool_page_free_list_allocator.sv @@
// Self-checking testbench for the two-pool page free-list allocator.
// Drives request items and APB register writes and checks every reply
// against an in-bench model of both page stacks. Depends on tpfl_pkg.
`timescale 1ns / 100ps

module tb_two_pool_page_free_list_allocator;
    import tpfl_pkg::*;

    localparam int PAGE_SHIFT  = 12;
    localparam int SUPER_SHIFT = 21;
    localparam int SMALL_DEPTH = 8192;
    localparam int SUPER_DEPTH = 64;
    localparam int STW = 14;
    localparam int PTW = 7;
    localparam int SMALL_PW = 32 - PAGE_SHIFT;
    localparam int SUPER_PW = 32 - SUPER_SHIFT;
    localparam logic [31:0] SMALL_SIZE = 32'd1 << PAGE_SHIFT;
    localparam logic [31:0] SUPER_SIZE = 32'd1 << SUPER_SHIFT;

    typedef struct {
        logic [31:0]    page_address;
        status_t        status;
        logic [STW-1:0] small_free_count;
        logic [PTW-1:0] super_free_count;
    } page_reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [2:0]         kind = '0;
    logic [31:0]        address = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [31:0]        page_address;
    logic [1:0]         status;
    logic [STW-1:0]     small_free_count;
    logic [PTW-1:0]     super_free_count;

    // Model of the allocator state.
    logic [31:0]             cfg_free_low = FREE_LOW_RESET;
    logic [31:0]             cfg_super_start = SUPER_START_RESET;
    logic [31:0]             cfg_phys_top = PHYS_TOP_RESET;
    logic [31-PAGE_SHIFT:0]  small_pages [SMALL_DEPTH];
    logic [31-SUPER_SHIFT:0] super_pages [SUPER_DEPTH];
    int unsigned             small_used = 0;
    int unsigned             super_used = 0;

    page_reply_t page_replies [$];
    int          mismatches = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    two_pool_page_free_list_allocator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .kind             (kind),
        .address          (address),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .page_address     (page_address),
        .status           (status),
        .small_free_count (small_free_count),
        .super_free_count (super_free_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("two_pool_page_free_list_allocator: mismatch");
        $finish;
    end

    // First page-aligned address at or above lo; may be 2^32.
    function automatic longint unsigned first_page(input logic [31:0] lo, input int shift);
        longint unsigned size;
        size = 64'd1 << shift;
        return ({32'd0, lo} + size - 1) & ~(size - 1);
    endfunction

    // Number of whole pages that fit in [lo, hi).
    function automatic longint unsigned whole_pages(input logic [31:0] lo,
                                                    input logic [31:0] hi, input int shift);
        longint unsigned first;
        first = first_page(lo, shift);
        if (first + (64'd1 << shift) > {32'd0, hi})
            return 64'd0;
        return ({32'd0, hi} - first) >> shift;
    endfunction

    // Applies one item to the model and queues the reply it must produce.
    task automatic step_page_pools(input logic [2:0] k, input logic [31:0] a);
        page_reply_t     r;
        longint unsigned n;
        longint unsigned base;
        r.page_address = '0;
        r.status = STATUS_OK;
        case (k)
            KIND_ALLOC_SMALL:
                if (small_used == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    small_used--;
                    r.page_address = {small_pages[small_used], {PAGE_SHIFT{1'b0}}};
                end
            KIND_ALLOC_SUPER:
                if (super_used == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    super_used--;
                    r.page_address = {super_pages[super_used], {SUPER_SHIFT{1'b0}}};
                end
            KIND_FREE_SMALL:
                if (a[PAGE_SHIFT-1:0] != '0 || a < cfg_free_low || a >= cfg_super_start)
                    r.status = STATUS_BAD;
                else if (small_used >= SMALL_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    small_pages[small_used] = a[31:PAGE_SHIFT];
                    small_used++;
                end
            KIND_FREE_SUPER:
                if (a[SUPER_SHIFT-1:0] != '0 || a < cfg_super_start || a >= cfg_phys_top)
                    r.status = STATUS_BAD;
                else if (super_used >= SUPER_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    super_pages[super_used] = a[31:SUPER_SHIFT];
                    super_used++;
                end
            KIND_INIT:
            begin
                n = whole_pages(cfg_free_low, cfg_super_start, PAGE_SHIFT);
                base = first_page(cfg_free_low, PAGE_SHIFT) >> PAGE_SHIFT;
                small_used = (n > SMALL_DEPTH) ? SMALL_DEPTH : 32'(n);
                for (int i = 0; i < small_used; i++)
                    small_pages[i] = SMALL_PW'(base + 64'(i));
                if (n > SMALL_DEPTH)
                    r.status = STATUS_FULL;
                n = whole_pages(cfg_super_start, cfg_phys_top, SUPER_SHIFT);
                base = first_page(cfg_super_start, SUPER_SHIFT) >> SUPER_SHIFT;
                super_used = (n > SUPER_DEPTH) ? SUPER_DEPTH : 32'(n);
                for (int i = 0; i < super_used; i++)
                    super_pages[i] = SUPER_PW'(base + 64'(i));
                if (n > SUPER_DEPTH)
                    r.status = STATUS_FULL;
            end
            default:
                ;
        endcase
        r.small_free_count = STW'(small_used);
        r.super_free_count = PTW'(super_used);
        page_replies.push_back(r);
    endtask

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(input logic [2:0] k, input logic [31:0] a);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            kind <= 3'($urandom);
            address <= $urandom;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        address <= a;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        step_page_pools(k, a);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (page_replies.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regions(input logic [31:0] lo, input logic [31:0] mid,
                               input logic [31:0] hi);
        wait_idle();
        write_reg(ADDR_FREE_LOW, lo);
        write_reg(ADDR_SUPER_START, mid);
        write_reg(ADDR_PHYS_TOP, hi);
        cfg_free_low = lo;
        cfg_super_start = mid;
        cfg_phys_top = hi;
    endtask

    // Reset values, boundaries of both regions, double free and unused kinds.
    task automatic test_default_regions();
        send_gap_pct = 0;
        stall_pct = 0;
        send_item(KIND_ALLOC_SMALL, 32'h0);
        send_item(KIND_ALLOC_SUPER, 32'h0);
        send_item(KIND_FREE_SMALL, 32'h8010_0000);
        send_item(KIND_ALLOC_SMALL, 32'h0);
        send_item(KIND_INIT, 32'hFFFF_FFFF);
        send_item(KIND_ALLOC_SMALL, 32'h0);
        send_item(KIND_ALLOC_SUPER, 32'h0);
        send_item(KIND_FREE_SMALL, 32'h81FF_F000);
        send_item(KIND_FREE_SMALL, 32'h8200_0000);
        send_item(KIND_FREE_SMALL, 32'h800F_F000);
        send_item(KIND_FREE_SMALL, 32'h8010_0800);
        send_item(KIND_FREE_SMALL, 32'hFFFF_FFFF);
        send_item(KIND_FREE_SUPER, 32'h8200_0000);
        send_item(KIND_FREE_SUPER, 32'h87E0_0000);
        send_item(KIND_FREE_SUPER, 32'h8800_0000);
        send_item(KIND_FREE_SUPER, 32'h81E0_0000);
        send_item(KIND_FREE_SUPER, 32'h8210_0000);
        send_item(KIND_FREE_SMALL, 32'h8010_0000);
        send_item(KIND_FREE_SMALL, 32'h8010_0000);
        send_item(KIND_ALLOC_SMALL, 32'h0);
        send_item(KIND_ALLOC_SMALL, 32'h0);
        send_item(3'd5, 32'hFFFF_FFFF);
        send_item(3'd6, 32'h0);
        send_item(3'd7, $urandom);
        send_item(KIND_ALLOC_SUPER, 32'hFFFF_FFFF);
    endtask

    // Overflowing init, full stacks, empty and inverted regions, unaligned bounds.
    task automatic test_pool_limits();
        send_gap_pct = 0;
        stall_pct = 0;
        set_regions(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(KIND_INIT, 32'h0);
        send_item(KIND_FREE_SMALL, 32'h0000_1000);
        send_item(KIND_FREE_SMALL, 32'h0000_1001);
        send_item(KIND_FREE_SUPER, 32'hFFE0_0000);
        send_item(KIND_ALLOC_SMALL, 32'h0);
        send_item(KIND_FREE_SMALL, 32'h0000_5000);
        send_item(KIND_FREE_SMALL, 32'h0000_6000);
        send_item(KIND_ALLOC_SUPER, 32'h0);
        set_regions(32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(KIND_INIT, 32'h0);
        send_item(KIND_FREE_SUPER, 32'h0);
        send_item(KIND_FREE_SUPER, 32'h0010_0000);
        send_item(KIND_ALLOC_SUPER, 32'h0);
        send_item(KIND_ALLOC_SMALL, 32'h0);
        set_regions(32'hFFFF_FFFF, 32'h0, 32'h0);
        send_item(KIND_INIT, 32'h0);
        send_item(KIND_FREE_SMALL, 32'hFFFF_F000);
        send_item(KIND_ALLOC_SMALL, 32'h0);
        send_item(KIND_ALLOC_SUPER, 32'h0);
        // Bounds off the page grid: three small pages and two superpages fit.
        set_regions(32'h8000_0800, 32'h8000_4FFF, 32'h8060_0000);
        send_item(KIND_INIT, 32'h0);
        repeat (4) send_item(KIND_ALLOC_SMALL, 32'h0);
        repeat (3) send_item(KIND_ALLOC_SUPER, 32'h0);
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_hold();
        send_gap_pct = 0;
        stall_pct = 0;
        set_regions(FREE_LOW_RESET, SUPER_START_RESET, PHYS_TOP_RESET);
        send_item(KIND_INIT, 32'h0);
        hold_left = 80;
        for (int i = 0; i < 12; i++)
            send_item(3'($urandom_range(3)),
                      {16'($urandom_range(32'h8200, 32'h8010)), 16'h0});
    endtask

    // Mostly well-formed alloc/free traffic on small random regions.
    task automatic test_random_traffic(input int items, input int gap, input int stall);
        logic [31:0]     lo;
        logic [31:0]     mid;
        logic [31:0]     hi;
        logic [31:0]     a;
        longint unsigned n;
        int              pick;
        send_gap_pct = 0;
        stall_pct = 0;
        lo = $urandom_range(32'h7FFF_FFFF, 0);
        mid = lo + $urandom_range(40, 0) * SMALL_SIZE + $urandom_range(SMALL_SIZE - 1, 0);
        hi = mid + $urandom_range(12, 0) * SUPER_SIZE + $urandom_range(SUPER_SIZE - 1, 0);
        set_regions(lo, mid, hi);
        send_gap_pct = gap;
        stall_pct = stall;
        send_item(KIND_INIT, $urandom);
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_item(KIND_ALLOC_SMALL, $urandom);
            else if (pick < 45)
                send_item(KIND_ALLOC_SUPER, $urandom);
            else if (pick < 68)
            begin
                n = whole_pages(cfg_free_low, cfg_super_start, PAGE_SHIFT);
                a = (n == 0) ? $urandom : 32'(first_page(cfg_free_low, PAGE_SHIFT)
                    + $urandom_range(32'(n - 1), 0) * SMALL_SIZE);
                send_item(KIND_FREE_SMALL, a);
            end
            else if (pick < 80)
            begin
                n = whole_pages(cfg_super_start, cfg_phys_top, SUPER_SHIFT);
                a = (n == 0) ? $urandom : 32'(first_page(cfg_super_start, SUPER_SHIFT)
                    + $urandom_range(32'(n - 1), 0) * SUPER_SIZE);
                send_item(KIND_FREE_SUPER, a);
            end
            else if (pick < 85)
                send_item(3'($urandom_range(3, 2)), $urandom);
            else if (pick < 90)
                // Just off the grid, just above the start of the superpage region.
                send_item(3'($urandom_range(3, 2)),
                          cfg_super_start + $urandom_range(SMALL_SIZE - 1, 1));
            else if (pick < 94)
                send_item(KIND_INIT, $urandom);
            else
                send_item(3'($urandom_range(7, 5)), $urandom);
        end
    endtask

    // Receiver: random stalls, or a counted hold when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        page_reply_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (page_replies.size() == 0)
            begin
                $error("reply with no item outstanding: page_address %h status %0d",
                       page_address, status);
                mismatches++;
            end
            else
            begin
                want = page_replies.pop_front();
                if (page_address !== want.page_address)
                begin
                    $error("page_address: expected %h, got %h", want.page_address, page_address);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (small_free_count !== want.small_free_count)
                begin
                    $error("small_free_count: expected %0d, got %0d",
                           want.small_free_count, small_free_count);
                    mismatches++;
                end
                if (super_free_count !== want.super_free_count)
                begin
                    $error("super_free_count: expected %0d, got %0d",
                           want.super_free_count, super_free_count);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_default_regions();
        test_pool_limits();
        test_output_hold();
        test_random_traffic(220, 0, 0);
        test_random_traffic(220, 45, 0);
        test_random_traffic(220, 0, 45);
        test_random_traffic(220, 31, 31);
        send_gap_pct = 0;
        stall_pct = 0;
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("two_pool_page_free_list_allocator: match");
        else
            $display("two_pool_page_free_list_allocator: mismatch");
        $finish;
    end

endmodule
